// ----- rtl/ecnfw_pkg.sv -----
package ecnfw_pkg;

  // window arithmetic width and alpha fixed point
  localparam int WinW     = 32;
  localparam int FracBits = 16;
  localparam int AlphaW   = FracBits + 1;
  localparam int CntW     = 32;
  localparam int MssW     = 14;
  localparam int ProdW    = CntW + MssW;
  localparam int DivCntW  = $clog2(AlphaW + 1);

  localparam logic [AlphaW-1:0] AlphaOne = {1'b1, {FracBits{1'b0}}};

  localparam logic [MssW-1:0] MssReset = MssW'(1500);
  localparam logic [MssW-1:0] PktReset = MssW'(1500);

  // event kinds
  localparam logic KindAck  = 1'b0;
  localparam logic KindLoss = 1'b1;

  // register indexes
  localparam logic RegMss = 1'b0;
  localparam logic RegPkt = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        ce_mark;
    logic [31:0] window_in;
    logic [31:0] threshold_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] window_out;
    logic [31:0] threshold_out;
    logic [16:0] alpha_out;
    logic        window_updated;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mult;
    logic div_start;
    logic div_step;
    logic alpha_upd;
    logic cut;
    logic floor_win;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_loss;
    logic due;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/ecnfw_ctrl.sv -----
module ecnfw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ecnfw_pkg::status_t status_i,
  output ecnfw_pkg::cmd_t    cmd_o
);
  import ecnfw_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MULT  = 8'b0000_0010,
    ST_TEST  = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_ALPHA = 8'b0001_0000,
    ST_CUT   = 8'b0010_0000,
    ST_FLOOR = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MULT;
        end
      end
      ST_MULT: begin
        // loss results are complete after the load
        if (status_i.is_loss) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.mult = 1'b1;
          state_d    = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status_i.due) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_ALPHA;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_ALPHA: begin
        cmd_o.alpha_upd = 1'b1;
        state_d         = ST_CUT;
      end
      ST_CUT: begin
        cmd_o.cut = 1'b1;
        state_d   = ST_FLOOR;
      end
      ST_FLOOR: begin
        cmd_o.floor_win = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MULT))
    else $error("accepted transfer did not start evaluation");

  a_no_step_past_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> !status_i.div_done)
    else $error("divider stepped after completion");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result emitted over a pending transfer");

endmodule

// ----- rtl/ecnfw_dpath.sv -----
module ecnfw_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ecnfw_pkg::cmd_t       cmd_i,
  output ecnfw_pkg::status_t    status_o,
  input  ecnfw_pkg::in_item_t   in_data_i,
  input  logic [ecnfw_pkg::MssW-1:0] mss_i,
  input  logic                  ref_load_i,
  input  logic [ecnfw_pkg::WinW-1:0] ref_value_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output ecnfw_pkg::out_item_t  out_data_o
);
  import ecnfw_pkg::*;

  logic              kind_q;
  logic [WinW-1:0]   win_q, thr_q, ref_q, cut_q;
  logic [CntW-1:0]   seen_q, marked_q;
  logic [AlphaW-1:0] alpha_q;
  logic [ProdW-1:0]  prod_q;
  logic              upd_q;
  logic [CntW:0]     div_r_q;
  logic [AlphaW-1:0] div_q_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [WinW-1:0]   win_in, thr_in, half, floor2, loss_thr, ack_thr, mss_w, win_f;
  logic [CntW-1:0]   seen_inc, marked_inc;
  logic [CntW:0]     rem_shift;
  logic              ge;
  logic [AlphaW-1:0] frac, alpha_new;
  logic [AlphaW+4:0] alpha_sum;
  logic [AlphaW:0]   alpha_raw, factor;
  logic [WinW+AlphaW:0] cut_prod;

  assign win_in   = WinW'(in_data_i.window_in);
  assign thr_in   = WinW'(in_data_i.threshold_in);
  assign half     = win_in >> 1;
  assign floor2   = WinW'({mss_i, 1'b0});
  assign loss_thr = (half > floor2) ? half : floor2;
  assign ack_thr  = (in_data_i.ce_mark && (thr_in > win_in)) ? win_in : thr_in;

  // saturating counters
  assign seen_inc   = (seen_q == '1) ? seen_q : seen_q + 1'b1;
  assign marked_inc = (marked_q == '1) ? marked_q : marked_q + 1'b1;

  // restoring division, first step without shift
  assign rem_shift = (div_cnt_q == '0) ? div_r_q : {div_r_q[CntW-1:0], 1'b0};
  assign ge        = (rem_shift >= {1'b0, seen_q});

  assign frac      = (div_q_q > AlphaOne) ? AlphaOne : div_q_q;
  assign alpha_sum = {1'b0, alpha_q, 4'b0000} - {5'b00000, alpha_q} + {5'b00000, frac};
  assign alpha_raw = alpha_sum[AlphaW+4:4];
  assign alpha_new = (alpha_raw > {1'b0, AlphaOne}) ? AlphaOne : alpha_raw[AlphaW-1:0];

  // window scale factor 2 - alpha in q(frac)
  assign factor   = {1'b1, {AlphaW{1'b0}}} - {1'b0, alpha_q};
  assign cut_prod = (WinW+AlphaW+1)'(win_q) * (WinW+AlphaW+1)'(factor);

  assign mss_w = WinW'(mss_i);
  assign win_f = (cut_q < mss_w) ? mss_w : cut_q;

  assign status_o.is_loss  = (kind_q == KindLoss);
  assign status_o.due      = (prod_q >= ProdW'(ref_q));
  assign status_o.div_done = (div_cnt_q == DivCntW'(AlphaW));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // event state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      marked_q    <= '0;
      alpha_q     <= '0;
      ref_q       <= WinW'({PktReset, 1'b0});
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ref_load_i) begin
        ref_q <= ref_value_i;
      end
      if (cmd_i.load) begin
        if (in_data_i.kind == KindLoss) begin
          seen_q   <= '0;
          marked_q <= '0;
          ref_q    <= win_in;
        end else begin
          seen_q <= seen_inc;
          if (in_data_i.ce_mark) begin
            marked_q <= marked_inc;
          end
        end
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.alpha_upd) begin
        alpha_q  <= alpha_new;
        seen_q   <= '0;
        marked_q <= '0;
      end
      if (cmd_i.floor_win) begin
        ref_q <= (alpha_q != '0) ? win_f : win_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_data_i.kind;
      win_q  <= win_in;
      upd_q  <= 1'b0;
      thr_q  <= (in_data_i.kind == KindLoss) ? loss_thr : ack_thr;
    end
    if (cmd_i.mult) begin
      prod_q <= ProdW'(seen_q) * ProdW'(mss_i);
    end
    if (cmd_i.div_start) begin
      div_r_q <= {1'b0, marked_q};
      div_q_q <= '0;
    end else if (cmd_i.div_step) begin
      div_r_q <= ge ? (rem_shift - {1'b0, seen_q}) : rem_shift;
      div_q_q <= {div_q_q[AlphaW-2:0], ge};
    end
    if (cmd_i.alpha_upd) begin
      upd_q <= 1'b1;
    end
    if (cmd_i.cut) begin
      cut_q <= cut_prod[AlphaW +: WinW];
    end
    if (cmd_i.floor_win && (alpha_q != '0)) begin
      win_q <= win_f;
      thr_q <= win_f;
    end
    if (cmd_i.emit) begin
      out_q.window_out     <= 32'(win_q);
      out_q.threshold_out  <= 32'(thr_q);
      out_q.alpha_out      <= 17'(alpha_q);
      out_q.window_updated <= upd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_alpha_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_q <= AlphaOne)
    else $error("alpha above one");

  a_marked_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    marked_q <= seen_q)
    else $error("marked count exceeds seen count");

endmodule

// ----- rtl/ecn_fraction_window_update.sv -----
// ecn-marked fraction window update
//
// input channel (in_valid_i / in_stall_o) carries one event a transfer:
// an acknowledgement (with its echo mark) or a loss, with the current
// window and threshold. every event gives exactly one result transfer
// on the output channel (out_valid_o / out_stall_i): new window,
// threshold, alpha and a flag for the once-per-window alpha update.
// one event is worked on at a time; in_stall_o is high while busy.
// a loss is complete after the load; an ack also runs the multiply and
// the due test, and an ack that closes a window then runs the 17-step
// restoring divider (one quotient bit a cycle) followed by the alpha,
// scale multiply and floor steps.
// results sit in an output register, so a new event is taken while the
// previous result still waits; a stalled receiver holds the block only
// once the next result is ready too.
// reset clears the counters and alpha, loads registers mss_bytes and
// packet_size with 1500 and the reference window with 2*packet_size.
// apb registers: 0x0 mss_bytes, 0x4 packet_size (a write reloads the
// ref window); the user writes only while the block is idle, unenforced
module ecn_fraction_window_update (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // event channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ecnfw_pkg::in_item_t   in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ecnfw_pkg::out_item_t  out_data_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ecnfw_pkg::*;

  logic [MssW-1:0] mss_q, pkt_q;
  logic            cfg_wr;
  logic            ref_load;
  cmd_t            cmd;
  status_t         status;

  // register file, word index from address bit 2
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign ref_load = cfg_wr && (paddr[2] == RegPkt);
  assign prdata   = (paddr[2] == RegPkt) ? 32'(pkt_q) : 32'(mss_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mss_q <= MssReset;
      pkt_q <= PktReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegMss:  mss_q <= pwdata[MssW-1:0];
        RegPkt:  pkt_q <= pwdata[MssW-1:0];
        default: mss_q <= mss_q;
      endcase
    end
  end

  // sequencing of evaluate, divide, alpha, scale and floor steps
  ecnfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, alpha, divider, multipliers and output register
  ecnfw_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .mss_i       (mss_q),
    .ref_load_i  (ref_load),
    .ref_value_i (WinW'({pwdata[MssW-1:0], 1'b0})),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/tb_ecn_fraction_window_update.sv -----
`timescale 1ns / 1ps

module tb_ecn_fraction_window_update;
  import ecnfw_pkg::*;

  // watchdog limit, far above the length of the slowest correct run
  localparam int unsigned CycleLimit   = 600_000;
  // settle time at the end, longer than the longest event latency
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned PhaseItems   = 225;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;

  // event channel
  logic      ev_valid = 1'b0;
  logic      ev_stall;
  in_item_t  ev_data = '0;

  // result channel
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_data;

  // configuration port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // our own copy of the window state and the registers
  logic [MssW-1:0]   cfg_mss = MssReset;
  logic [MssW-1:0]   cfg_pkt = PktReset;
  logic [CntW-1:0]   acks_seen = '0;
  logic [CntW-1:0]   acks_marked = '0;
  logic [AlphaW-1:0] alpha_est = '0;
  logic [31:0]       ref_window = 32'd3000;

  // expected results, oldest first
  out_item_t pending_results[$];

  // window and threshold of the emulated flow, fed back from the predicted results
  logic [31:0] flow_win = 32'd3000;
  logic [31:0] flow_thr = 32'd3000;

  // idling controls, the hold-off request is counted down by the result side
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned rx_hold_req = 0;

  int unsigned errors = 0;
  int unsigned n_events = 0;
  int unsigned n_losses = 0;
  int unsigned n_updates = 0;
  int unsigned n_results = 0;
  int unsigned n_writes = 0;
  int unsigned cycle_count = 0;

  ecn_fraction_window_update u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_stall_o  (ev_stall),
    .in_data_i   (ev_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles with %0d results still due", cycle_count,
               pending_results.size());
      $display("tb_ecn_fraction_window_update failed");
      $finish;
    end
  end

  function automatic in_item_t make_event(input logic kind, input logic echo,
                                          input logic [31:0] win, input logic [31:0] thr);
    in_item_t ev;
    ev.kind         = kind;
    ev.ce_mark      = echo;
    ev.window_in    = win;
    ev.threshold_in = thr;
    return ev;
  endfunction

  // window reaction to one event; updates the counters, alpha and reference window
  function automatic out_item_t window_reaction(input in_item_t ev);
    out_item_t   res;
    logic [63:0] win;
    logic [63:0] thr;
    logic [63:0] mss;
    logic [63:0] frac;
    logic [63:0] avg;
    res = '0;
    win = 64'(ev.window_in);
    thr = 64'(ev.threshold_in);
    mss = 64'(cfg_mss);
    if (ev.kind == KindLoss) begin
      // echo ignored, window passes through, alpha kept
      acks_seen   = '0;
      acks_marked = '0;
      thr = ((win >> 1) > (mss << 1)) ? (win >> 1) : (mss << 1);
      ref_window = win[31:0];
    end else begin
      if (acks_seen != '1) acks_seen = acks_seen + 1'b1;
      if (ev.ce_mark) begin
        if (acks_marked != '1) acks_marked = acks_marked + 1'b1;
        if (thr > win) thr = win;
      end
      if (64'(acks_seen) * mss >= 64'(ref_window)) begin
        frac = (64'(acks_marked) << FracBits) / 64'(acks_seen);
        if (frac > 64'(AlphaOne)) frac = 64'(AlphaOne);
        avg = (64'd15 * 64'(alpha_est) + frac) >> 4;
        if (avg > 64'(AlphaOne)) avg = 64'(AlphaOne);
        alpha_est   = avg[AlphaW-1:0];
        acks_seen   = '0;
        acks_marked = '0;
        res.window_updated = 1'b1;
        // a zero alpha leaves window and threshold alone
        if (alpha_est != '0) begin
          win = (win * (64'd2 * 64'(AlphaOne) - 64'(alpha_est))) >> (FracBits + 1);
          if (win < mss) win = mss;
          thr = win;
        end
        ref_window = win[31:0];
      end
    end
    res.window_out    = win[31:0];
    res.threshold_out = thr[31:0];
    res.alpha_out     = alpha_est;
    return res;
  endfunction

  // offer one event, wait for its transfer and queue the expected result
  task automatic send_event(input in_item_t ev, output out_item_t predicted);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      ev_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_data  <= ev;
    do @(posedge clk); while (ev_stall);
    predicted = window_reaction(ev);
    pending_results.push_back(predicted);
    n_events++;
    if (ev.kind == KindLoss) n_losses++;
    if (predicted.window_updated) n_updates++;
  endtask

  // sender goes quiet until every expected result has been taken
  task automatic drain_results();
    ev_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write a register, then read it back; only called while the block is idle
  task automatic program_reg(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // only the low 14 bits are kept; packet size reloads the reference window
    if (idx == RegMss) begin
      cfg_mss = value[MssW-1:0];
    end else begin
      cfg_pkt    = value[MssW-1:0];
      ref_window = 32'(cfg_pkt) << 1;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== 32'(value[MssW-1:0])) begin
      $error("register %0d readback: expected %0d, actual %0d", idx, value[MssW-1:0],
             readback);
      errors++;
    end
    n_writes++;
  endtask

  // one event of an emulated flow: mostly acks on the tracked window,
  // some losses and some random noise
  task automatic next_flow_event(input int unsigned mark_pct);
    in_item_t    ev;
    out_item_t   res;
    int unsigned roll;
    logic [63:0] unit;
    logic [63:0] grown;
    unit = (cfg_mss == '0) ? 64'd1 : 64'(cfg_mss);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      ev = make_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom);
    end else if (roll < 13) begin
      ev = make_event(KindLoss, 1'($urandom_range(0, 1)), flow_win, flow_thr);
    end else if (roll < 30) begin
      ev = make_event(KindAck, 1'($urandom_range(1, 100) <= mark_pct), flow_win,
                      $urandom_range(0, 2 * flow_win));
    end else begin
      ev = make_event(KindAck, 1'($urandom_range(1, 100) <= mark_pct), flow_win, flow_thr);
    end
    send_event(ev, res);
    // additive growth between cuts, kept within a few dozen segments
    grown = 64'(res.window_out) + 64'($urandom_range(0, 32'(unit)));
    if (grown > 64'd48 * unit) grown = 64'd48 * unit;
    flow_win = grown[31:0];
    flow_thr = res.threshold_out;
  endtask

  // compare one result transfer with the oldest expectation
  task automatic check_result(input out_item_t got);
    out_item_t want;
    n_results++;
    if (pending_results.size() == 0) begin
      $error("result with no event waiting: window_out %0d", got.window_out);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.window_out !== want.window_out) begin
      $error("window_out: expected %0d, actual %0d", want.window_out, got.window_out);
      errors++;
    end
    if (got.threshold_out !== want.threshold_out) begin
      $error("threshold_out: expected %0d, actual %0d", want.threshold_out,
             got.threshold_out);
      errors++;
    end
    if (got.alpha_out !== want.alpha_out) begin
      $error("alpha_out: expected %0d, actual %0d", want.alpha_out, got.alpha_out);
      errors++;
    end
    if (got.window_updated !== want.window_updated) begin
      $error("window_updated: expected %0d, actual %0d", want.window_updated,
             got.window_updated);
      errors++;
    end
  endtask

  // result side: checks every transfer, then stalls for a drawn number of
  // cycles; a hold-off request overrides that for a long stretch
  initial begin : result_side
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && res_valid && !res_stall) begin
        check_result(res_data);
        stall_left = rx_idle_on ? $urandom_range(0, 16) : 0;
      end
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // hand-picked events: zero-alpha update, mark capping, losses at both
  // window extremes, floor at the mss, and both register extremes
  task automatic test_directed();
    out_item_t res;
    // reset values: mss 1500, reference window 3000
    send_event(make_event(KindAck, 1'b0, 32'd3000, 32'd5000), res);
    send_event(make_event(KindAck, 1'b0, 32'd3000, 32'd5000), res);
    send_event(make_event(KindAck, 1'b1, 32'd3000, 32'hFFFF_FFFF), res);
    send_event(make_event(KindAck, 1'b1, 32'd3000, 32'd0), res);
    send_event(make_event(KindLoss, 1'b1, 32'hFFFF_FFFF, 32'd0), res);
    send_event(make_event(KindAck, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), res);
    send_event(make_event(KindLoss, 1'b0, 32'd0, 32'd1234), res);
    send_event(make_event(KindAck, 1'b0, 32'd0, 32'd0), res);
    send_event(make_event(KindAck, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), res);
    send_event(make_event(KindLoss, 1'b0, 32'd2, 32'd9), res);
    drain_results();
    // largest mss, zero packet size: every ack closes a window, cut floors at mss
    program_reg(RegMss, 32'd16383);
    program_reg(RegPkt, 32'd0);
    send_event(make_event(KindAck, 1'b1, 32'd100, 32'd200), res);
    send_event(make_event(KindAck, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555), res);
    send_event(make_event(KindAck, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA), res);
    drain_results();
    // bits above the register width are dropped, leaving mss at zero
    program_reg(RegMss, 32'hFFFF_C000);
    send_event(make_event(KindAck, 1'b1, 32'd5000, 32'd6000), res);
    send_event(make_event(KindLoss, 1'b0, 32'd1, 32'd7), res);
    send_event(make_event(KindAck, 1'b0, 32'd1, 32'd7), res);
    send_event(make_event(KindLoss, 1'b1, 32'd0, 32'd0), res);
    send_event(make_event(KindAck, 1'b1, 32'd64, 32'd0), res);
    drain_results();
    program_reg(RegMss, 32'd64);
    program_reg(RegPkt, 32'hFFFF_FFFF);
    send_event(make_event(KindAck, 1'b1, 32'd640, 32'd9999), res);
    send_event(make_event(KindAck, 1'b1, 32'd640, 32'd100), res);
    drain_results();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // then the sender pauses until everything has come back
  task automatic test_backpressure();
    program_reg(RegMss, 32'd1500);
    program_reg(RegPkt, 32'd1500);
    flow_win    = 32'd6000;
    flow_thr    = 32'd6000;
    tx_idle_on  = 1'b0;
    rx_hold_req = 300;
    repeat (30) next_flow_event(60);
    drain_results();
    tx_idle_on = 1'b1;
    repeat (12) next_flow_event(60);
    drain_results();
  endtask

  // flows under several register settings, the extremes among them
  task automatic test_random_flows();
    int unsigned phase_mss[8] = '{1500, 64, 9000, 64, 9000, 16383, 0, 0};
    int unsigned phase_pkt[8] = '{1500, 64, 9000, 9000, 64, 16383, 0, 0};
    int unsigned mark_pct;
    for (int p = 0; p < 8; p++) begin
      if (p >= 6) begin
        phase_mss[p] = $urandom_range(64, 9000);
        phase_pkt[p] = $urandom_range(64, 9000);
      end
      drain_results();
      program_reg(RegMss, phase_mss[p]);
      program_reg(RegPkt, phase_pkt[p]);
      flow_win = 32'(phase_pkt[p]) << 1;
      flow_thr = flow_win;
      mark_pct = $urandom_range(0, 100);
      for (int i = 0; i < PhaseItems; i++) begin
        // new idling mix and marking rate now and then, no-idle stretches included
        if (i % 40 == 0) begin
          tx_idle_on = ($urandom_range(0, 3) != 0);
          rx_idle_on = ($urandom_range(0, 3) != 0);
          mark_pct   = $urandom_range(0, 100);
        end
        if (i % 97 == 96) drain_results();
        next_flow_event(mark_pct);
      end
    end
  endtask

  initial begin : run
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_flows();
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    $display("%0d events sent (%0d losses, %0d alpha updates), %0d results checked",
             n_events, n_losses, n_updates, n_results);
    $display("%0d register writes, mss and packet size from 0 to 16383", n_writes);
    if (errors == 0) begin
      $display("tb_ecn_fraction_window_update passed");
    end else begin
      $display("tb_ecn_fraction_window_update failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ecnfw_pkg.sv
rtl/ecnfw_ctrl.sv
rtl/ecnfw_dpath.sv
rtl/ecn_fraction_window_update.sv
dv/tb_ecn_fraction_window_update.sv
